// ===== design/rsti_pkg.sv =====
// ----------------------------------------------------------------------------
// rsti_pkg
// Types, constants and saturating arithmetic helpers shared by the ray segment
// versus triangle intersection pipeline, its multiplier and its checker.
// ----------------------------------------------------------------------------
package rsti_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
   localparam int WIDE_WIDTH  = 64;
   localparam int HALF_WIDTH  = WIDE_WIDTH / 2;
   localparam int EPS_WIDTH   = 16;

   localparam int REQ_DATA_WIDTH = ((9 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8;
   localparam int STATUS_WIDTH   = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [EDGE_WIDTH-1:0]  edge_type;
   typedef logic signed [WIDE_WIDTH-1:0]  wide_type;
   typedef logic        [WIDE_WIDTH-1:0]  mag_type;
   typedef logic        [FRAC_BITS:0]     quot_type;
   typedef logic        [EPS_WIDTH-1:0]   eps_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_HIT        = 3'd0,
      STATUS_SHORT      = 3'd1,
      STATUS_MISS       = 3'd2,
      STATUS_COPLANAR   = 3'd3,
      STATUS_DEGENERATE = 3'd4
   } status_type;

   localparam wide_type WIDE_MAX = {1'b0, {(WIDE_WIDTH-1){1'b1}}};
   localparam wide_type WIDE_MIN = {1'b1, {(WIDE_WIDTH-1){1'b0}}};
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // Pipeline stage numbers. A multiplier group issued at stage S has its
   // products registered alongside stage S+1.
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES   = (FRAC_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
   localparam int ST_EDGE      = 1;
   localparam int ST_G1        = 2;
   localparam int ST_CROSS     = 4;
   localparam int ST_G2        = 5;
   localparam int ST_DET       = 7;
   localparam int ST_SNAP      = 8;
   localparam int ST_G3        = 9;
   localparam int ST_PLANE     = 11;
   localparam int ST_CLASS     = 12;
   localparam int ST_DIV0      = 13;
   localparam int ST_DIVN      = ST_DIV0 + DIV_STAGES - 1;
   localparam int ST_G4        = ST_DIVN + 1;
   localparam int ST_HIT       = ST_G4 + 2;
   localparam int ST_G5        = ST_HIT + 1;
   localparam int ST_DOTW      = ST_G5 + 2;
   localparam int ST_G6        = ST_DOTW + 1;
   localparam int ST_SNTN      = ST_G6 + 2;
   localparam int ST_FINAL     = ST_SNTN + 1;
   localparam int NUM_STAGES   = ST_FINAL;

   // Multiplier index ranges, one range per issue stage.
   localparam int MUL_G1   = 0;
   localparam int MUL_G2   = MUL_G1 + 15;
   localparam int MUL_G3   = MUL_G2 + 2;
   localparam int MUL_G4   = MUL_G3 + 6;
   localparam int MUL_G5   = MUL_G4 + 3;
   localparam int MUL_G6   = MUL_G5 + 6;
   localparam int NUM_MULS = MUL_G6 + 4;

   typedef struct packed {
      mag_type  rem;
      quot_type q;
   } div_type;

   typedef struct {
      logic       is_test;
      logic       early;
      status_type status;
      coord_type  p   [3];
      coord_type  d   [3];
      coord_type  c   [3];
      coord_type  org [3];
      edge_type   e1  [3];
      edge_type   e2  [3];
      edge_type   w   [3];
      coord_type  h   [3];
      wide_type   n   [3];
      wide_type   uu;
      wide_type   uv;
      wide_type   vv;
      wide_type   dd;
      wide_type   num;
      wide_type   den;
      wide_type   wu;
      wide_type   wv;
      wide_type   sn;
      wide_type   tn;
      mag_type    ub;
      div_type    dv;
   } stage_type;

   function automatic int mul_stage(int i);
      if (i < MUL_G2) return ST_G1;
      else if (i < MUL_G3) return ST_G2;
      else if (i < MUL_G4) return ST_G3;
      else if (i < MUL_G5) return ST_G4;
      else if (i < MUL_G6) return ST_G5;
      else return ST_G6;
   endfunction

   function automatic mag_type mag(wide_type a);
      return a[WIDE_WIDTH-1] ? mag_type'(-a) : mag_type'(a);
   endfunction

   function automatic wide_type sat_add(wide_type a, wide_type b);
      logic signed [WIDE_WIDTH:0] s;
      s = {a[WIDE_WIDTH-1], a} + {b[WIDE_WIDTH-1], b};
      if (s[WIDE_WIDTH] != s[WIDE_WIDTH-1]) return s[WIDE_WIDTH] ? WIDE_MIN : WIDE_MAX;
      return s[WIDE_WIDTH-1:0];
   endfunction

   function automatic wide_type sat_sub(wide_type a, wide_type b);
      logic signed [WIDE_WIDTH:0] s;
      s = {a[WIDE_WIDTH-1], a} - {b[WIDE_WIDTH-1], b};
      if (s[WIDE_WIDTH] != s[WIDE_WIDTH-1]) return s[WIDE_WIDTH] ? WIDE_MIN : WIDE_MAX;
      return s[WIDE_WIDTH-1:0];
   endfunction

   function automatic wide_type sat_neg(wide_type a);
      return (a == WIDE_MIN) ? WIDE_MAX : -a;
   endfunction

   function automatic logic near_zero(wide_type x, eps_type eps);
      return (x == '0) || (mag(x) < mag_type'(eps));
   endfunction

   function automatic coord_type clamp_coord(wide_type x);
      if (x > wide_type'(COORD_MAX)) return COORD_MAX;
      if (x < wide_type'(COORD_MIN)) return COORD_MIN;
      return x[COORD_WIDTH-1:0];
   endfunction

   // One restoring step of the fractional ratio.
   function automatic div_type div_step(div_type s, mag_type ub);
      div_type r;
      r.rem = {s.rem[WIDE_WIDTH-2:0], 1'b0};
      r.q   = {s.q[FRAC_BITS-1:0], 1'b0};
      if (r.rem >= ub) begin
         r.rem = r.rem - ub;
         r.q[0] = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== design/rsti_mulq.sv =====
// ----------------------------------------------------------------------------
// rsti_mulq
// Two-stage signed fixed point multiplier: four 32x32 partial products, then
// recombination, truncation of the fraction toward zero and saturation.
// ----------------------------------------------------------------------------
module rsti_mulq
   import rsti_pkg::*;
(
   input  logic     clock,
   input  logic     en_a,
   input  logic     en_b,
   input  wide_type a,
   input  wide_type b,
   output wide_type prod
);

   logic [WIDE_WIDTH-1:0]   ll_ff, lh_ff, hl_ff, hh_ff;
   logic                    neg_ff;
   wide_type                prod_ff;
   mag_type                 x, y;
   logic [2*WIDE_WIDTH-1:0] full, shifted;
   logic                    over;
   mag_type                 lo;
   wide_type                prod_in;

   assign x = mag(a);
   assign y = mag(b);

   always_ff @(posedge clock) begin
      if (en_a) begin
         neg_ff <= a[WIDE_WIDTH-1] != b[WIDE_WIDTH-1];
         ll_ff  <= x[HALF_WIDTH-1:0] * y[HALF_WIDTH-1:0];
         lh_ff  <= x[HALF_WIDTH-1:0] * y[WIDE_WIDTH-1:HALF_WIDTH];
         hl_ff  <= x[WIDE_WIDTH-1:HALF_WIDTH] * y[HALF_WIDTH-1:0];
         hh_ff  <= x[WIDE_WIDTH-1:HALF_WIDTH] * y[WIDE_WIDTH-1:HALF_WIDTH];
      end
      if (en_b) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      full = {{WIDE_WIDTH{1'b0}}, ll_ff}
           + ({{WIDE_WIDTH{1'b0}}, lh_ff} << HALF_WIDTH)
           + ({{WIDE_WIDTH{1'b0}}, hl_ff} << HALF_WIDTH)
           + {hh_ff, {WIDE_WIDTH{1'b0}}};
      shifted = full >> FRAC_BITS;
      over    = |shifted[2*WIDE_WIDTH-1:WIDE_WIDTH];
      lo      = shifted[WIDE_WIDTH-1:0];
      if (neg_ff) begin
         prod_in = (over || lo[WIDE_WIDTH-1]) ? WIDE_MIN : -wide_type'(lo);
      end else begin
         prod_in = (over || lo[WIDE_WIDTH-1]) ? WIDE_MAX : wide_type'(lo);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== design/ray_segment_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_segment_triangle_intersect
// Tests ray segments against a stored triangle in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A load request (tuser 0) stores a triangle and returns nothing; a test
// request (tuser 1) returns one response with a status and the plane hit
// point. The block takes one request per cycle unless back pressure stalls
// its first stage. The 36 two-stage multipliers and the two-steps-per-stage
// ratio divider set the depth from an accepted test request to its response.
// A load takes effect for every test request accepted after it. Back pressure
// on the response side stalls only the stages that are full, so bubbles close up.
// ----------------------------------------------------------------------------
module ray_segment_triangle_intersect
   import rsti_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // req_type
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // hit_x, hit_y, hit_z
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // hit_status
   output logic [STATUS_WIDTH-1:0]   rsp_tuser,
   input  logic                      csr_we,
   input  logic [EPS_WIDTH-1:0]      csr_wdata
);

   eps_type   eps_ff;
   stage_type pl_ff [1:NUM_STAGES];
   stage_type pl_in [1:NUM_STAGES];
   logic      v_ff  [1:NUM_STAGES];
   logic      v_in  [1:NUM_STAGES];
   logic      en    [1:NUM_STAGES+1];

   coord_type st_org_ff [3];
   edge_type  st_e1_ff  [3];
   edge_type  st_e2_ff  [3];
   wide_type  st_n_ff   [3];
   wide_type  st_uu_ff, st_uv_ff, st_vv_ff, st_dd_ff;
   logic      commit;

   wide_type mul_a [NUM_MULS];
   wide_type mul_b [NUM_MULS];
   wide_type mul_p [NUM_MULS];

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= eps_type'(1);
      end else if (csr_we) begin
         eps_ff <= csr_wdata;
      end
   end

   // A stage moves when it is empty or the stage after it moves.
   always_comb begin
      en[NUM_STAGES+1] = rsp_tready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[1];

   always_comb begin
      v_in[1] = req_tvalid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         v_in[k] = v_ff[k-1];
      end
      // Loads leave the pipeline once they have updated the stored triangle.
      v_in[ST_SNAP] = v_ff[ST_DET] && pl_ff[ST_DET].is_test;
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
         if (en[k]) begin
            pl_ff[k] <= pl_in[k];
         end
      end
   end

   assign commit = v_ff[ST_DET] && !pl_ff[ST_DET].is_test && en[ST_DET+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            st_org_ff[i] <= '0;
            st_e1_ff[i]  <= '0;
            st_e2_ff[i]  <= '0;
            st_n_ff[i]   <= '0;
         end
         st_uu_ff <= '0;
         st_uv_ff <= '0;
         st_vv_ff <= '0;
         st_dd_ff <= '0;
      end else if (commit) begin
         for (int i = 0; i < 3; i++) begin
            st_org_ff[i] <= pl_ff[ST_DET].p[i];
            st_e1_ff[i]  <= pl_ff[ST_DET].e1[i];
            st_e2_ff[i]  <= pl_ff[ST_DET].e2[i];
            st_n_ff[i]   <= pl_ff[ST_DET].n[i];
         end
         st_uu_ff <= pl_ff[ST_DET].uu;
         st_uv_ff <= pl_ff[ST_DET].uv;
         st_vv_ff <= pl_ff[ST_DET].vv;
         st_dd_ff <= pl_ff[ST_DET].dd;
      end
   end

   // Multiplier operands, each group taken from the register before its issue stage.
   always_comb begin
      mul_a[MUL_G1+0] = wide_type'(pl_ff[ST_G1-1].e1[1]);
      mul_b[MUL_G1+0] = wide_type'(pl_ff[ST_G1-1].e2[2]);
      mul_a[MUL_G1+1] = wide_type'(pl_ff[ST_G1-1].e1[2]);
      mul_b[MUL_G1+1] = wide_type'(pl_ff[ST_G1-1].e2[1]);
      mul_a[MUL_G1+2] = wide_type'(pl_ff[ST_G1-1].e1[2]);
      mul_b[MUL_G1+2] = wide_type'(pl_ff[ST_G1-1].e2[0]);
      mul_a[MUL_G1+3] = wide_type'(pl_ff[ST_G1-1].e1[0]);
      mul_b[MUL_G1+3] = wide_type'(pl_ff[ST_G1-1].e2[2]);
      mul_a[MUL_G1+4] = wide_type'(pl_ff[ST_G1-1].e1[0]);
      mul_b[MUL_G1+4] = wide_type'(pl_ff[ST_G1-1].e2[1]);
      mul_a[MUL_G1+5] = wide_type'(pl_ff[ST_G1-1].e1[1]);
      mul_b[MUL_G1+5] = wide_type'(pl_ff[ST_G1-1].e2[0]);
      for (int i = 0; i < 3; i++) begin
         mul_a[MUL_G1+6+i]  = wide_type'(pl_ff[ST_G1-1].e1[i]);
         mul_b[MUL_G1+6+i]  = wide_type'(pl_ff[ST_G1-1].e1[i]);
         mul_a[MUL_G1+9+i]  = wide_type'(pl_ff[ST_G1-1].e1[i]);
         mul_b[MUL_G1+9+i]  = wide_type'(pl_ff[ST_G1-1].e2[i]);
         mul_a[MUL_G1+12+i] = wide_type'(pl_ff[ST_G1-1].e2[i]);
         mul_b[MUL_G1+12+i] = wide_type'(pl_ff[ST_G1-1].e2[i]);
      end
      mul_a[MUL_G2+0] = pl_ff[ST_G2-1].uv;
      mul_b[MUL_G2+0] = pl_ff[ST_G2-1].uv;
      mul_a[MUL_G2+1] = pl_ff[ST_G2-1].uu;
      mul_b[MUL_G2+1] = pl_ff[ST_G2-1].vv;
      for (int i = 0; i < 3; i++) begin
         mul_a[MUL_G3+i]   = pl_ff[ST_G3-1].n[i];
         mul_b[MUL_G3+i]   = wide_type'(pl_ff[ST_G3-1].w[i]);
         mul_a[MUL_G3+3+i] = pl_ff[ST_G3-1].n[i];
         mul_b[MUL_G3+3+i] = wide_type'(pl_ff[ST_G3-1].d[i]);
         mul_a[MUL_G4+i]   = {{(WIDE_WIDTH-FRAC_BITS-1){1'b0}}, pl_ff[ST_G4-1].dv.q};
         mul_b[MUL_G4+i]   = wide_type'(pl_ff[ST_G4-1].d[i]);
         mul_a[MUL_G5+i]   = wide_type'(pl_ff[ST_G5-1].w[i]);
         mul_b[MUL_G5+i]   = wide_type'(pl_ff[ST_G5-1].e1[i]);
         mul_a[MUL_G5+3+i] = wide_type'(pl_ff[ST_G5-1].w[i]);
         mul_b[MUL_G5+3+i] = wide_type'(pl_ff[ST_G5-1].e2[i]);
      end
      mul_a[MUL_G6+0] = pl_ff[ST_G6-1].uv;
      mul_b[MUL_G6+0] = pl_ff[ST_G6-1].wv;
      mul_a[MUL_G6+1] = pl_ff[ST_G6-1].vv;
      mul_b[MUL_G6+1] = pl_ff[ST_G6-1].wu;
      mul_a[MUL_G6+2] = pl_ff[ST_G6-1].uv;
      mul_b[MUL_G6+2] = pl_ff[ST_G6-1].wu;
      mul_a[MUL_G6+3] = pl_ff[ST_G6-1].uu;
      mul_b[MUL_G6+3] = pl_ff[ST_G6-1].wv;
   end

   for (genvar gi = 0; gi < NUM_MULS; gi++) begin : g_mul
      localparam int IssueStage = mul_stage(gi);
      rsti_mulq u_mulq (
         .clock (clock),
         .en_a  (en[IssueStage]),
         .en_b  (en[IssueStage+1]),
         .a     (mul_a[gi]),
         .b     (mul_b[gi]),
         .prod  (mul_p[gi])
      );
   end

   always_comb begin
      stage_type s;
      wide_type  dd_f, sn_f, tn_f;
      mag_type   ua, ub;

      for (int k = 2; k <= NUM_STAGES; k++) begin
         pl_in[k] = pl_ff[k-1];
      end

      // Unpack the request and form the edges of a load.
      s = pl_ff[1];
      s.is_test = req_tuser;
      s.early   = 1'b0;
      s.status  = STATUS_HIT;
      for (int i = 0; i < 3; i++) begin
         s.p[i]  = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
         s.d[i]  = req_tdata[(3+i)*COORD_WIDTH +: COORD_WIDTH];
         s.c[i]  = req_tdata[(6+i)*COORD_WIDTH +: COORD_WIDTH];
         s.e1[i] = edge_type'(s.d[i]) - edge_type'(s.p[i]);
         s.e2[i] = edge_type'(s.c[i]) - edge_type'(s.p[i]);
      end
      pl_in[ST_EDGE] = s;

      // Normal and edge dot products.
      pl_in[ST_CROSS].n[0] = sat_sub(mul_p[MUL_G1+0], mul_p[MUL_G1+1]);
      pl_in[ST_CROSS].n[1] = sat_sub(mul_p[MUL_G1+2], mul_p[MUL_G1+3]);
      pl_in[ST_CROSS].n[2] = sat_sub(mul_p[MUL_G1+4], mul_p[MUL_G1+5]);
      pl_in[ST_CROSS].uu = sat_add(sat_add(mul_p[MUL_G1+6], mul_p[MUL_G1+7]),
                                   mul_p[MUL_G1+8]);
      pl_in[ST_CROSS].uv = sat_add(sat_add(mul_p[MUL_G1+9], mul_p[MUL_G1+10]),
                                   mul_p[MUL_G1+11]);
      pl_in[ST_CROSS].vv = sat_add(sat_add(mul_p[MUL_G1+12], mul_p[MUL_G1+13]),
                                   mul_p[MUL_G1+14]);

      pl_in[ST_DET].dd = sat_sub(mul_p[MUL_G2+0], mul_p[MUL_G2+1]);

      // A test takes its copy of the stored triangle here, in request order.
      s = pl_ff[ST_SNAP-1];
      for (int i = 0; i < 3; i++) begin
         s.org[i] = st_org_ff[i];
         s.e1[i]  = st_e1_ff[i];
         s.e2[i]  = st_e2_ff[i];
         s.n[i]   = st_n_ff[i];
         s.w[i]   = edge_type'(s.p[i]) - edge_type'(st_org_ff[i]);
      end
      s.uu = st_uu_ff;
      s.uv = st_uv_ff;
      s.vv = st_vv_ff;
      s.dd = st_dd_ff;
      if (near_zero(st_n_ff[0], eps_ff) && near_zero(st_n_ff[1], eps_ff) &&
          near_zero(st_n_ff[2], eps_ff)) begin
         s.early  = 1'b1;
         s.status = STATUS_DEGENERATE;
      end
      pl_in[ST_SNAP] = s;

      pl_in[ST_PLANE].num = sat_neg(sat_add(sat_add(mul_p[MUL_G3+0], mul_p[MUL_G3+1]),
                                            mul_p[MUL_G3+2]));
      pl_in[ST_PLANE].den = sat_add(sat_add(mul_p[MUL_G3+3], mul_p[MUL_G3+4]),
                                    mul_p[MUL_G3+5]);

      // Classify against the plane and set up the ratio.
      s  = pl_ff[ST_CLASS-1];
      ua = mag(s.num);
      ub = mag(s.den);
      if (!s.early) begin
         if (near_zero(s.den, eps_ff)) begin
            s.early  = 1'b1;
            s.status = near_zero(s.num, eps_ff) ? STATUS_COPLANAR : STATUS_MISS;
         end else if ((s.num != '0) && (s.num[WIDE_WIDTH-1] != s.den[WIDE_WIDTH-1])) begin
            s.early  = 1'b1;
            s.status = STATUS_MISS;
         end else if (ua > ub) begin
            s.early  = 1'b1;
            s.status = STATUS_SHORT;
         end
      end
      s.ub     = ub;
      s.dv.q   = quot_type'(ua == ub);
      s.dv.rem = (ua == ub) ? '0 : ua;
      pl_in[ST_CLASS] = s;

      for (int k = ST_DIV0; k <= ST_DIVN; k++) begin
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            if ((k - ST_DIV0) * DIV_STEPS_PER_STAGE + j < FRAC_BITS) begin
               pl_in[k].dv = div_step(pl_in[k].dv, pl_in[k].ub);
            end
         end
      end

      for (int i = 0; i < 3; i++) begin
         pl_in[ST_HIT].h[i] = clamp_coord(sat_add(wide_type'(pl_ff[ST_HIT-1].p[i]),
                                                  mul_p[MUL_G4+i]));
         pl_in[ST_HIT].w[i] = edge_type'(pl_in[ST_HIT].h[i])
                            - edge_type'(pl_ff[ST_HIT-1].org[i]);
      end

      pl_in[ST_DOTW].wu = sat_add(sat_add(mul_p[MUL_G5+0], mul_p[MUL_G5+1]),
                                  mul_p[MUL_G5+2]);
      pl_in[ST_DOTW].wv = sat_add(sat_add(mul_p[MUL_G5+3], mul_p[MUL_G5+4]),
                                  mul_p[MUL_G5+5]);

      pl_in[ST_SNTN].sn = sat_sub(mul_p[MUL_G6+0], mul_p[MUL_G6+1]);
      pl_in[ST_SNTN].tn = sat_sub(mul_p[MUL_G6+2], mul_p[MUL_G6+3]);

      // Inside test in barycentric form, signs folded onto a positive determinant.
      s    = pl_ff[ST_FINAL-1];
      dd_f = s.dd;
      sn_f = s.sn;
      tn_f = s.tn;
      if (dd_f[WIDE_WIDTH-1]) begin
         dd_f = sat_neg(s.dd);
         sn_f = sat_neg(s.sn);
         tn_f = sat_neg(s.tn);
      end
      if (!s.early) begin
         if (s.dd == '0) begin
            s.status = STATUS_MISS;
         end else if (sn_f < 0 || sn_f > dd_f || tn_f < 0 || sat_add(sn_f, tn_f) > dd_f) begin
            s.status = STATUS_MISS;
         end else begin
            s.status = STATUS_HIT;
         end
      end
      if (s.status != STATUS_HIT) begin
         for (int i = 0; i < 3; i++) begin
            s.h[i] = '0;
         end
      end
      pl_in[ST_FINAL] = s;
   end

   assign rsp_tvalid = v_ff[NUM_STAGES];
   assign rsp_tuser  = pl_ff[NUM_STAGES].status;

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < 3; i++) begin
         rsp_tdata[i*COORD_WIDTH +: COORD_WIDTH] = pl_ff[NUM_STAGES].h[i];
      end
   end

endmodule

// ===== design/rsti_checker.sv =====
// ----------------------------------------------------------------------------
// rsti_checker
// Port-level checks on the response channel of the intersection block.
// ----------------------------------------------------------------------------
module rsti_checker
   import rsti_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [STATUS_WIDTH-1:0]   rsp_tuser
);

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed or dropped");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STATUS_HIT || rsp_tuser == STATUS_SHORT ||
                     rsp_tuser == STATUS_MISS || rsp_tuser == STATUS_COPLANAR ||
                     rsp_tuser == STATUS_DEGENERATE)
      else $error("response status out of range");

   // Only a hit carries a point.
   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_HIT |-> rsp_tdata == '0)
      else $error("non-hit response carries a point");

endmodule

bind ray_segment_triangle_intersect rsti_checker u_rsti_checker (.*);
